// ===== rtl/core/pvjh_pkg.sv =====
package pvjh_pkg;

  localparam int NEIGHBORS = 8;
  localparam int NB_IDX_W  = 3;
  localparam int VAL_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int SCALE_W   = 24;
  localparam int BINS_W    = 7;
  localparam int KEY_W     = 6;
  localparam int ADDR_W    = 12;
  localparam int ACC_W     = 48;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    ACT_ACCUM        = 3'd0,
    ACT_CLEAR        = 3'd1,
    ACT_LOAD_FKEY    = 3'd2,
    ACT_LOAD_MKEY    = 3'd3,
    ACT_READ_FIXED   = 3'd4,
    ACT_READ_MOVING  = 3'd5,
    ACT_READ_JOINT   = 3'd6
  } action_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_OFFSET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_BINS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_USE_KEYS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVING_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVING_SCALE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVING_BINS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVING_USE_KEYS = 3'd7;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W-1:0] add);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + {1'b0, add};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/core/pvjh_binner.sv =====
module pvjh_binner
  import pvjh_pkg::*;
#(
  parameter int MAX_BINS    = 64,
  parameter int KEY_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic signed [VAL_W-1:0]             value,
  input  logic signed [VAL_W-1:0]             offset,
  input  logic [SCALE_W-1:0]                  scale,
  input  logic [$clog2(MAX_BINS+1)-1:0]       nb,
  output logic [$clog2(MAX_BINS)-1:0]         eq_bin,
  output logic                                eq_sat,
  output logic [$clog2(KEY_ENTRIES)-1:0]      key_idx,
  output logic                                key_sat
);

  localparam int BINW  = $clog2(MAX_BINS);
  localparam int KAW   = $clog2(KEY_ENTRIES);
  localparam int PW    = VAL_W + 1 + SCALE_W + 1;
  localparam int FINEW = PW - 16;

  logic signed [VAL_W:0]   diff;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    prod_q;
  logic signed [FINEW-1:0] fine;
  logic                    neg;

  assign diff = VAL_W'(value) - VAL_W'(offset) == 0 ? '0 : 
                {value[VAL_W-1], value} - {offset[VAL_W-1], offset};
  assign prod = PW'(diff) * PW'($signed({1'b0, scale}));

  // floor of the Q.16 product is the upper bits
  assign fine = prod_q[PW-1:16];
  assign neg  = fine[FINEW-1];

  always_ff @(posedge clk) begin
    prod_q <= prod;
    if (neg) begin
      eq_bin  <= '0;
      eq_sat  <= 1'b1;
      key_idx <= '0;
      key_sat <= 1'b1;
    end else begin
      if (FINEW'(nb) <= fine) begin
        eq_bin <= BINW'(nb - 1'b1);
        eq_sat <= 1'b1;
      end else begin
        eq_bin <= BINW'(fine);
        eq_sat <= 1'b0;
      end
      if (FINEW'(KEY_ENTRIES) <= fine) begin
        key_idx <= KAW'(KEY_ENTRIES - 1);
        key_sat <= 1'b1;
      end else begin
        key_idx <= KAW'(fine);
        key_sat <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/pvjh_weight.sv =====
module pvjh_weight
  import pvjh_pkg::*;
(
  input  logic              clk,
  input  logic [FRAC_W-1:0] a,
  input  logic [FRAC_W-1:0] b,
  input  logic [FRAC_W-1:0] c,
  output logic [FRAC_W-1:0] weight
);

  logic [2*FRAC_W-1:0] p_ab;
  logic [FRAC_W-1:0]   c_q;
  logic [3*FRAC_W-1:0] p_abc;

  assign p_abc = (3*FRAC_W)'(p_ab) * (3*FRAC_W)'(c_q);

  always_ff @(posedge clk) begin
    p_ab   <= a * b;
    c_q    <= c;
    // keep Q0.16: drop the low 32 bits
    weight <= p_abc[3*FRAC_W-1:2*FRAC_W];
  end

endmodule

// ===== rtl/core/partial_volume_joint_histogram.sv =====
// Partial-volume joint histogram. An accumulate word bins one fixed voxel and
// eight moving neighbors in eight parallel lanes (plus one for the fixed voxel),
// forms the eight trilinear weights in eight weight lanes, then bumps the fixed
// count and adds each weight to the moving and joint bins, one neighbor at a
// time against single-port histogram memories. An accumulate runs from
// acceptance to its result through lane work, key lookup and the fixed-count
// update, then a read-modify-write of the moving and joint bins per neighbor.
// A clear sweeps the fixed, moving and joint memories but not the key tables.
// After reset the block zeroes histograms and key tables before it takes a
// word; configuration writes are taken throughout.
module partial_volume_joint_histogram
  import pvjh_pkg::*;
#(
  parameter int MAX_BINS    = 64,
  parameter int KEY_ENTRIES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // fixed_value, moving_values_lo, moving_values_hi, frac_lo_x, frac_lo_y,
  // frac_lo_z, frac_hi_x, frac_hi_y, frac_hi_z, entry_address, key_value, pad
  input  logic [263:0]         s_tdata,
  // action
  input  logic [2:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // read_value, fixed_bin_used, pad
  output logic [55:0]          m_tdata,
  // status
  output logic [1:0]           m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int BINW   = $clog2(MAX_BINS);
  localparam int NBW    = $clog2(MAX_BINS + 1);
  localparam int KAW    = $clog2(KEY_ENTRIES);
  localparam int JDEPTH = MAX_BINS * MAX_BINS;
  localparam int JAW    = $clog2(JDEPTH);
  localparam int SWEEP  = (JDEPTH > KEY_ENTRIES) ? JDEPTH : KEY_ENTRIES;
  localparam int CNTW   = $clog2(SWEEP);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC1, S_CALC2, S_FKEY, S_FBIN, S_FWR, S_MRD, S_MWR, S_RD, S_CLR, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic signed [VAL_W-1:0] f_offset, m_offset;
  logic [SCALE_W-1:0]      f_scale, m_scale;
  logic [BINS_W-1:0]       f_bins, m_bins;
  logic                    f_use_keys, m_use_keys;
  logic [NBW-1:0]          fnb, mnb;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_offset   <= '0;
      f_scale    <= SCALE_W'(65536);
      f_bins     <= BINS_W'(32);
      f_use_keys <= 1'b0;
      m_offset   <= '0;
      m_scale    <= SCALE_W'(65536);
      m_bins     <= BINS_W'(32);
      m_use_keys <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIXED_OFFSET:    f_offset   <= cfg_data[VAL_W-1:0];
        CFG_FIXED_SCALE:     f_scale    <= cfg_data[SCALE_W-1:0];
        CFG_FIXED_BINS:      f_bins     <= cfg_data[BINS_W-1:0];
        CFG_FIXED_USE_KEYS:  f_use_keys <= cfg_data[0];
        CFG_MOVING_OFFSET:   m_offset   <= cfg_data[VAL_W-1:0];
        CFG_MOVING_SCALE:    m_scale    <= cfg_data[SCALE_W-1:0];
        CFG_MOVING_BINS:     m_bins     <= cfg_data[BINS_W-1:0];
        CFG_MOVING_USE_KEYS: m_use_keys <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [NBW-1:0] eff_bins(input logic [BINS_W-1:0] b);
    if (b == '0) return NBW'(1);
    if (32'(b) > MAX_BINS) return NBW'(MAX_BINS);
    return NBW'(b);
  endfunction

  assign fnb = eff_bins(f_bins);
  assign mnb = eff_bins(m_bins);

  // held item
  logic [2:0]              it_action;
  logic signed [VAL_W-1:0] it_fixed;
  logic [63:0]             it_mlo, it_mhi;
  logic [FRAC_W-1:0]       it_lx, it_ly, it_lz, it_hx, it_hy, it_hz;
  logic [ADDR_W-1:0]       it_addr;

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      it_action <= s_tuser;
      it_fixed  <= s_tdata[15:0];
      it_mlo    <= s_tdata[79:16];
      it_mhi    <= s_tdata[143:80];
      it_lx     <= s_tdata[159:144];
      it_ly     <= s_tdata[175:160];
      it_lz     <= s_tdata[191:176];
      it_hx     <= s_tdata[207:192];
      it_hy     <= s_tdata[223:208];
      it_hz     <= s_tdata[239:224];
      it_addr   <= s_tdata[251:240];
    end
  end

  // lanes
  logic [BINW-1:0]   f_eq_bin;
  logic              f_eq_sat, f_key_sat;
  logic [KAW-1:0]    f_key_idx;
  logic [BINW-1:0]   l_eq_bin [NEIGHBORS];
  logic              l_eq_sat [NEIGHBORS];
  logic [KAW-1:0]    l_key_idx [NEIGHBORS];
  logic              l_key_sat [NEIGHBORS];
  logic [FRAC_W-1:0] l_weight [NEIGHBORS];

  pvjh_binner #(.MAX_BINS(MAX_BINS), .KEY_ENTRIES(KEY_ENTRIES)) u_fixed_bin (
    .clk(clk), .value(it_fixed), .offset(f_offset), .scale(f_scale), .nb(fnb),
    .eq_bin(f_eq_bin), .eq_sat(f_eq_sat), .key_idx(f_key_idx), .key_sat(f_key_sat)
  );

  for (genvar k = 0; k < NEIGHBORS; k++) begin : g_lane
    logic signed [VAL_W-1:0] mv;
    if (k < 4) begin : g_lo
      assign mv = it_mlo[16*k +: 16];
    end else begin : g_hi
      assign mv = it_mhi[16*(k-4) +: 16];
    end

    pvjh_binner #(.MAX_BINS(MAX_BINS), .KEY_ENTRIES(KEY_ENTRIES)) u_bin (
      .clk(clk), .value(mv), .offset(m_offset), .scale(m_scale), .nb(mnb),
      .eq_bin(l_eq_bin[k]), .eq_sat(l_eq_sat[k]), .key_idx(l_key_idx[k]),
      .key_sat(l_key_sat[k])
    );

    pvjh_weight u_weight (
      .clk(clk),
      .a((k & 1) != 0 ? it_hx : it_lx),
      .b((k & 2) != 0 ? it_hy : it_ly),
      .c((k & 4) != 0 ? it_hz : it_lz),
      .weight(l_weight[k])
    );
  end

  // sequencer registers
  logic [NB_IDX_W-1:0] n;
  logic [NB_IDX_W-1:0] n_nxt;
  logic [CNTW-1:0]     cnt;
  logic                clr_keys;
  logic [BINW-1:0]     fb, mb;
  logic [JAW-1:0]      jbase, jidx;
  logic                sat;

  assign n_nxt = n + 1'b1;

  // memories
  logic [ACC_W-1:0] fc_mem [MAX_BINS];
  logic [ACC_W-1:0] ms_mem [MAX_BINS];
  logic [ACC_W-1:0] js_mem [JDEPTH];
  logic [KEY_W-1:0] fk_mem [KEY_ENTRIES];
  logic [KEY_W-1:0] mk_mem [KEY_ENTRIES];
  logic [ACC_W-1:0] fc_rd, ms_rd, js_rd;
  logic [KEY_W-1:0] fk_rd, mk_rd;

  logic             fc_we, ms_we, js_we, fk_we, mk_we;
  logic             fc_re, ms_re, js_re, fk_re, mk_re;
  logic [BINW-1:0]  fc_wa, ms_wa, fc_ra, ms_ra;
  logic [JAW-1:0]   js_wa, js_ra;
  logic [KAW-1:0]   k_wa, fk_ra, mk_ra;
  logic [ACC_W-1:0] fc_wd, ms_wd, js_wd;
  logic [KEY_W-1:0] k_wd;

  // bin choice after the key lookup
  logic [BINW-1:0]  fb_next, mb_next;
  logic             fsat_next, msat_next;
  logic [ACC_W-1:0] w_ext;

  always_comb begin
    if (f_use_keys) begin
      if (32'(fk_rd) >= 32'(fnb)) begin
        fb_next   = BINW'(fnb - 1'b1);
        fsat_next = 1'b1;
      end else begin
        fb_next   = BINW'(fk_rd);
        fsat_next = f_key_sat;
      end
    end else begin
      fb_next   = f_eq_bin;
      fsat_next = f_eq_sat;
    end
    if (m_use_keys) begin
      if (32'(mk_rd) >= 32'(mnb)) begin
        mb_next   = BINW'(mnb - 1'b1);
        msat_next = 1'b1;
      end else begin
        mb_next   = BINW'(mk_rd);
        msat_next = l_key_sat[n];
      end
    end else begin
      mb_next   = l_eq_bin[n];
      msat_next = l_eq_sat[n];
    end
  end

  assign w_ext = ACC_W'(l_weight[n]);

  logic in_clr_bins, in_clr_joint, in_clr_keys;
  logic ld_ok;
  assign in_clr_bins  = (state == S_CLR) && (32'(cnt) < MAX_BINS);
  assign in_clr_joint = (state == S_CLR) && (32'(cnt) < JDEPTH);
  assign in_clr_keys  = (state == S_CLR) && clr_keys && (32'(cnt) < KEY_ENTRIES);
  assign ld_ok        = 32'(s_tdata[251:240]) < KEY_ENTRIES;

  always_comb begin
    fc_we = in_clr_bins || (state == S_FWR);
    fc_wa = (state == S_CLR) ? BINW'(cnt) : fb;
    fc_wd = (state == S_CLR) ? '0 : sat_add(fc_rd, ACC_W'(1));
    ms_we = in_clr_bins || (state == S_MWR);
    ms_wa = (state == S_CLR) ? BINW'(cnt) : mb;
    ms_wd = (state == S_CLR) ? '0 : sat_add(ms_rd, w_ext);
    js_we = in_clr_joint || (state == S_MWR);
    js_wa = (state == S_CLR) ? JAW'(cnt) : jidx;
    js_wd = (state == S_CLR) ? '0 : sat_add(js_rd, w_ext);

    fk_we = in_clr_keys || (accept && s_tuser == ACT_LOAD_FKEY && ld_ok);
    mk_we = in_clr_keys || (accept && s_tuser == ACT_LOAD_MKEY && ld_ok);
    k_wa  = (state == S_CLR) ? KAW'(cnt) : KAW'(s_tdata[251:240]);
    k_wd  = (state == S_CLR) ? '0 : s_tdata[257:252];

    fc_re = (state == S_RD) || (state == S_FBIN);
    fc_ra = (state == S_FBIN) ? fb_next : BINW'(it_addr);
    ms_re = (state == S_RD) || (state == S_MRD);
    ms_ra = (state == S_MRD) ? mb_next : BINW'(it_addr);
    js_re = ms_re;
    js_ra = (state == S_MRD) ? (jbase + JAW'(mb_next)) : JAW'(it_addr);

    fk_re = (state == S_FKEY);
    fk_ra = f_key_idx;
    mk_re = (state == S_FKEY) || (state == S_MRD);
    mk_ra = (state == S_FKEY) ? l_key_idx[0] : l_key_idx[n_nxt];
  end

  always_ff @(posedge clk) begin
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    if (fc_re) fc_rd <= fc_mem[fc_ra];
  end

  always_ff @(posedge clk) begin
    if (ms_we) ms_mem[ms_wa] <= ms_wd;
    if (ms_re) ms_rd <= ms_mem[ms_ra];
  end

  always_ff @(posedge clk) begin
    if (js_we) js_mem[js_wa] <= js_wd;
    if (js_re) js_rd <= js_mem[js_ra];
  end

  always_ff @(posedge clk) begin
    if (fk_we) fk_mem[k_wa] <= k_wd;
    if (fk_re) fk_rd <= fk_mem[fk_ra];
  end

  always_ff @(posedge clk) begin
    if (mk_we) mk_mem[k_wa] <= k_wd;
    if (mk_re) mk_rd <= mk_mem[mk_ra];
  end

  // result of the held word
  logic [ACC_W-1:0] res_value;
  logic [1:0]       res_status;

  always_comb begin
    res_value  = '0;
    res_status = STATUS_OK;
    unique case (it_action)
      ACT_ACCUM: res_status = sat ? STATUS_SAT : STATUS_OK;
      ACT_LOAD_FKEY, ACT_LOAD_MKEY: begin
        if (32'(it_addr) >= KEY_ENTRIES) res_status = STATUS_RANGE;
      end
      ACT_READ_FIXED, ACT_READ_MOVING: begin
        if (32'(it_addr) >= MAX_BINS) res_status = STATUS_RANGE;
        else res_value = (it_action == ACT_READ_FIXED) ? fc_rd : ms_rd;
      end
      ACT_READ_JOINT: begin
        if (32'(it_addr) >= JDEPTH) res_status = STATUS_RANGE;
        else res_value = js_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      cnt      <= '0;
      clr_keys <= 1'b1;
      n        <= '0;
      sat      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the output word once taken, unless a new one replaces it
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (s_tuser)
              ACT_ACCUM: state <= S_CALC1;
              ACT_CLEAR: begin
                state    <= S_CLR;
                cnt      <= '0;
                clr_keys <= 1'b0;
              end
              ACT_READ_FIXED, ACT_READ_MOVING, ACT_READ_JOINT: state <= S_RD;
              default: state <= S_FIN;
            endcase
          end
        end
        S_CALC1: state <= S_CALC2;
        S_CALC2: state <= S_FKEY;
        S_FKEY:  state <= S_FBIN;
        S_FBIN: begin
          fb    <= fb_next;
          sat   <= fsat_next;
          state <= S_FWR;
        end
        S_FWR: begin
          jbase <= JAW'(32'(fb) * 32'(mnb));
          n     <= '0;
          state <= S_MRD;
        end
        S_MRD: begin
          mb    <= mb_next;
          jidx  <= jbase + JAW'(mb_next);
          sat   <= sat | msat_next;
          state <= S_MWR;
        end
        S_MWR: begin
          n <= n_nxt;
          if (32'(n) == NEIGHBORS - 1) state <= S_FIN;
          else state <= S_MRD;
        end
        S_RD: state <= S_FIN;
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (clr_keys && 32'(cnt) == SWEEP - 1) begin
            state    <= S_IDLE;
            clr_keys <= 1'b0;
          end else if (!clr_keys && 32'(cnt) == JDEPTH - 1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output word is free
          if (!m_tvalid || m_tready) begin
            m_tvalid       <= 1'b1;
            m_tdata[47:0]  <= res_value;
            m_tdata[53:48] <= (it_action == ACT_ACCUM) ? KEY_W'(fb) : '0;
            m_tdata[55:54] <= '0;
            m_tuser        <= res_status;
            sat            <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb_partial_volume_joint_histogram.sv =====
`timescale 1ns / 100ps

module tb_partial_volume_joint_histogram;
  import pvjh_pkg::*;

  localparam int BIN_LIMIT = 64;
  localparam int KEY_DEPTH = 1024;
  localparam int JOINT_DEPTH = BIN_LIMIT * BIN_LIMIT;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam longint unsigned ACC_TOP = 64'hFFFF_FFFF_FFFF;
  localparam int AXIS_FIXED = 0;
  localparam int AXIS_MOVING = 1;

  typedef struct {
    logic [ACC_W-1:0] read_value;
    logic [5:0]       fixed_bin;
    logic [1:0]       status;
  } hist_result_t;

  class histogram_scoreboard;
    int               offset_q[2];
    int unsigned      scale_q[2];
    int unsigned      bins_q[2];
    bit               keys_on[2];
    logic [KEY_W-1:0] key_tab[2][KEY_DEPTH];
    longint unsigned  fixed_count[BIN_LIMIT];
    longint unsigned  moving_sum[BIN_LIMIT];
    longint unsigned  joint_sum[JOINT_DEPTH];
    hist_result_t     pending_q[$];
    int               errors;

    function new();
      for (int a = 0; a < 2; a++) begin
        offset_q[a] = 0;
        scale_q[a] = 65536;
        bins_q[a] = 32;
        keys_on[a] = 0;
        for (int i = 0; i < KEY_DEPTH; i++) key_tab[a][i] = '0;
      end
      clear_hist();
      errors = 0;
    endfunction

    function void clear_hist();
      foreach (fixed_count[i]) fixed_count[i] = 0;
      foreach (moving_sum[i]) moving_sum[i] = 0;
      foreach (joint_sum[i]) joint_sum[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      int a;
      a = (idx < CFG_MOVING_OFFSET) ? AXIS_FIXED : AXIS_MOVING;
      case (idx[1:0])
        2'd0: offset_q[a] = int'($signed(data[15:0]));
        2'd1: scale_q[a] = 32'(data);
        2'd2: bins_q[a] = 32'(data[BINS_W-1:0]);
        default: keys_on[a] = data[0];
      endcase
    endfunction

    function int unsigned bin_count(int a);
      if (bins_q[a] == 0) return 1;
      if (bins_q[a] > BIN_LIMIT) return BIN_LIMIT;
      return bins_q[a];
    endfunction

    function int unsigned coarse_bin(logic signed [15:0] v, int a, inout bit sat);
      longint prod, fine;
      int unsigned nb, idx, k;
      nb = bin_count(a);
      prod = longint'(int'(v) - offset_q[a]) * longint'(scale_q[a]);
      fine = prod >>> 16;
      if (keys_on[a]) begin
        if (fine < 0) begin
          idx = 0; sat = 1;
        end else if (fine >= KEY_DEPTH) begin
          idx = KEY_DEPTH - 1; sat = 1;
        end else begin
          idx = 32'(fine);
        end
        k = 32'(key_tab[a][idx]);
        if (k >= nb) begin
          k = nb - 1; sat = 1;
        end
        return k;
      end
      if (fine < 0) begin
        sat = 1; return 0;
      end
      if (fine >= nb) begin
        sat = 1; return nb - 1;
      end
      return 32'(fine);
    endfunction

    function longint unsigned add_capped(longint unsigned acc, longint unsigned inc);
      longint unsigned s;
      s = acc + inc;
      return (s > ACC_TOP) ? ACC_TOP : s;
    endfunction

    function void note_word(logic [2:0] act, logic [263:0] d);
      hist_result_t r;
      logic [127:0] nbr;
      logic [11:0] addr;
      longint unsigned fr[6];
      longint unsigned w;
      int unsigned fb, mb, mnb;
      bit sat;
      r = '{default: '0};
      nbr = d[143:16];
      addr = d[251:240];
      sat = 0;
      case (act)
        ACT_ACCUM: begin
          for (int i = 0; i < 6; i++) fr[i] = 64'(d[144 + 16*i +: 16]);
          fb = coarse_bin(d[15:0], AXIS_FIXED, sat);
          fixed_count[fb] = add_capped(fixed_count[fb], 1);
          mnb = bin_count(AXIS_MOVING);
          for (int k = 0; k < 8; k++) begin
            // bit 0 picks x, bit 1 y, bit 2 z: lower fraction on 0, upper on 1
            w = (fr[k[0] ? 3 : 0] * fr[k[1] ? 4 : 1] * fr[k[2] ? 5 : 2]) >> 32;
            mb = coarse_bin(nbr[16*k +: 16], AXIS_MOVING, sat);
            moving_sum[mb] = add_capped(moving_sum[mb], w);
            joint_sum[fb*mnb + mb] = add_capped(joint_sum[fb*mnb + mb], w);
          end
          r.fixed_bin = 6'(fb);
          r.status = sat ? STATUS_SAT : STATUS_OK;
        end
        ACT_CLEAR: clear_hist();
        ACT_LOAD_FKEY, ACT_LOAD_MKEY: begin
          if (addr < KEY_DEPTH)
            key_tab[(act == ACT_LOAD_FKEY) ? AXIS_FIXED : AXIS_MOVING][addr] = d[257:252];
          else
            r.status = STATUS_RANGE;
        end
        ACT_READ_FIXED, ACT_READ_MOVING: begin
          if (addr < BIN_LIMIT)
            r.read_value = ACC_W'((act == ACT_READ_FIXED) ? fixed_count[addr]
                                                           : moving_sum[addr]);
          else
            r.status = STATUS_RANGE;
        end
        ACT_READ_JOINT: begin
          if (addr < JOINT_DEPTH) r.read_value = ACC_W'(joint_sum[addr]);
          else r.status = STATUS_RANGE;
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_word(logic [ACC_W-1:0] rv, logic [5:0] fbu, logic [1:0] st);
      hist_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result word: read_value %0h fixed_bin_used %0d status %0d",
               rv, fbu, st);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (rv !== e.read_value) begin
        $error("read_value: expected %0h, got %0h", e.read_value, rv);
        errors++;
      end
      if (fbu !== e.fixed_bin) begin
        $error("fixed_bin_used: expected %0d, got %0d", e.fixed_bin, fbu);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [263:0]         s_tdata = '0;
  logic [2:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 0;
  logic [55:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  histogram_scoreboard hist_sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  partial_volume_joint_histogram dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (m_tvalid && m_tready) hist_sb.check_word(m_tdata[47:0], m_tdata[53:48], m_tuser);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [263:0] pack_word(logic [15:0] fv, logic [127:0] nbr,
                                             logic [95:0] fr, logic [11:0] addr,
                                             logic [5:0] key);
    return {6'b0, key, addr, fr, nbr, fv};
  endfunction

  task automatic send_word(logic [2:0] act, logic [263:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    hist_sb.note_word(act, d);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    hist_sb.set_reg(idx, data);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (hist_sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] voxel_near(int off);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(off + int'($urandom_range(2300)) - 200);
  endfunction

  function automatic logic [95:0] rand_fracs();
    logic [95:0] f;
    logic [15:0] lo;
    case ($urandom_range(3))
      0: begin
        for (int i = 0; i < 3; i++) begin
          lo = 16'($urandom);
          f[16*i +: 16] = lo;
          f[48 + 16*i +: 16] = 16'hFFFF - lo;
        end
      end
      1: for (int i = 0; i < 6; i++) f[16*i +: 16] = $urandom_range(1) ? 16'hFFFF : 16'h0;
      default: for (int i = 0; i < 6; i++) f[16*i +: 16] = 16'($urandom);
    endcase
    return f;
  endfunction

  task automatic random_word();
    logic [127:0] nbr;
    logic [11:0] addr;
    logic [2:0] act;
    int r;
    r = $urandom_range(999);
    for (int k = 0; k < 8; k++) nbr[16*k +: 16] = voxel_near(hist_sb.offset_q[AXIS_MOVING]);
    addr = 12'($urandom);
    if (r < 600) begin
      act = ACT_ACCUM;
    end else if (r < 700) begin
      act = (r < 650) ? ACT_LOAD_FKEY : ACT_LOAD_MKEY;
      if ($urandom_range(9) != 0) addr = 12'($urandom_range(KEY_DEPTH - 1));
    end else if (r < 980) begin
      act = (r < 780) ? ACT_READ_FIXED : (r < 860) ? ACT_READ_MOVING : ACT_READ_JOINT;
      if (act != ACT_READ_JOINT && $urandom_range(6) != 0)
        addr = 12'($urandom_range(BIN_LIMIT - 1));
    end else if (r < 990) begin
      act = ACT_CLEAR;
    end else begin
      act = ACT_UNUSED;
    end
    send_word(act, pack_word(voxel_near(hist_sb.offset_q[AXIS_FIXED]), nbr, rand_fracs(),
                             addr, 6'($urandom)));
  endtask

  task automatic apply_settings(int p);
    case (p)
      1: begin
        write_reg(CFG_FIXED_OFFSET, 24'h00_8000);
        write_reg(CFG_FIXED_SCALE, 24'hFF_FFFF);
        write_reg(CFG_FIXED_BINS, 24'd64);
        write_reg(CFG_FIXED_USE_KEYS, 24'd1);
        write_reg(CFG_MOVING_OFFSET, 24'h00_7FFF);
        write_reg(CFG_MOVING_SCALE, 24'd0);
        write_reg(CFG_MOVING_BINS, 24'd0);
        write_reg(CFG_MOVING_USE_KEYS, 24'd0);
      end
      2: begin
        write_reg(CFG_FIXED_OFFSET, 24'($urandom_range(65535)));
        write_reg(CFG_FIXED_SCALE, 24'd2048);
        write_reg(CFG_FIXED_BINS, 24'd127);
        write_reg(CFG_FIXED_USE_KEYS, 24'd0);
        write_reg(CFG_MOVING_OFFSET, 24'($urandom_range(65535)));
        write_reg(CFG_MOVING_SCALE, 24'd8192);
        write_reg(CFG_MOVING_BINS, 24'd40);
        write_reg(CFG_MOVING_USE_KEYS, 24'd1);
      end
      3: begin
        write_reg(CFG_FIXED_OFFSET, 24'd0);
        write_reg(CFG_FIXED_SCALE, 24'd4096);
        write_reg(CFG_FIXED_BINS, 24'd16);
        write_reg(CFG_FIXED_USE_KEYS, 24'd1);
        write_reg(CFG_MOVING_OFFSET, 24'h00_FF00);
        write_reg(CFG_MOVING_SCALE, 24'd4096);
        write_reg(CFG_MOVING_BINS, 24'd64);
        write_reg(CFG_MOVING_USE_KEYS, 24'd1);
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [127:0] nbr;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, every action, range corners
    nbr = {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h001F, 16'h0020, 16'h0010, 16'h0001};
    send_word(ACT_ACCUM, pack_word(16'h0000, nbr, {96{1'b1}}, 12'd0, 6'd0));
    send_word(ACT_ACCUM, pack_word(16'h8000, nbr, '0, 12'd0, 6'd0));
    send_word(ACT_ACCUM, pack_word(16'h7FFF, ~nbr, {48'h0, {48{1'b1}}}, 12'd0, 6'd0));
    send_word(ACT_ACCUM, pack_word(16'h0005, nbr, {48{2'b10}}, 12'd0, 6'd0));
    send_word(ACT_READ_FIXED, pack_word('0, '0, '0, 12'd0, 6'd0));
    send_word(ACT_READ_FIXED, pack_word('0, '0, '0, 12'd31, 6'd0));
    send_word(ACT_READ_FIXED, pack_word('0, '0, '0, 12'd63, 6'd0));
    send_word(ACT_READ_FIXED, pack_word('0, '0, '0, 12'd64, 6'd0));
    send_word(ACT_READ_MOVING, pack_word('0, '0, '0, 12'd1, 6'd0));
    send_word(ACT_READ_MOVING, pack_word('0, '0, '0, 12'hFFF, 6'd0));
    send_word(ACT_READ_JOINT, pack_word('0, '0, '0, 12'd31, 6'd0));
    send_word(ACT_READ_JOINT, pack_word('0, '0, '0, 12'hFFF, 6'd0));
    send_word(ACT_LOAD_FKEY, pack_word('0, '0, '0, 12'd0, 6'd63));
    send_word(ACT_LOAD_FKEY, pack_word('0, '0, '0, 12'd1023, 6'd5));
    send_word(ACT_LOAD_FKEY, pack_word('0, '0, '0, 12'd1024, 6'd7));
    send_word(ACT_LOAD_MKEY, pack_word('0, '0, '0, 12'd1023, 6'd63));
    send_word(ACT_LOAD_MKEY, pack_word('0, '0, '0, 12'hFFF, 6'd1));
    send_word(ACT_UNUSED, pack_word(16'hFFFF, {128{1'b1}}, {96{1'b1}}, 12'hFFF, 6'd63));
    send_word(ACT_CLEAR, pack_word('0, '0, '0, 12'd0, 6'd0));
    send_word(ACT_READ_JOINT, pack_word('0, '0, '0, 12'd31, 6'd0));
    send_word(ACT_READ_FIXED, pack_word('0, '0, '0, 12'd0, 6'd0));

    for (int p = 0; p < 4; p++) begin
      drain();
      apply_settings(p);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // seed the key tables so remapped bins spread out
      for (int i = 0; i < 24; i++)
        send_word($urandom_range(1) ? ACT_LOAD_FKEY : ACT_LOAD_MKEY,
                  pack_word('0, '0, '0, 12'($urandom_range(KEY_DEPTH - 1)), 6'($urandom)));
      for (int i = 0; i < 260; i++) random_word();
    end

    s_tvalid <= 0;
    while (hist_sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (hist_sb.errors == 0) begin
      $display("** partial_volume_joint_histogram: PASSED **");
    end else begin
      $display("** partial_volume_joint_histogram: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** partial_volume_joint_histogram: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pvjh_pkg.sv
rtl/core/pvjh_binner.sv
rtl/core/pvjh_weight.sv
rtl/core/partial_volume_joint_histogram.sv
test/tb_partial_volume_joint_histogram.sv
